FILE: rtl/pdr_pkg.sv
`default_nettype none
package pdr_pkg;

  // Field widths of the command and result items.
  localparam int SPEED_W = 8;
  localparam int DUR_W   = 16;
  localparam int NUM_W   = SPEED_W + DUR_W;

  // Number of serial steps in the multiply and divide units (one bit each).
  localparam int STEPS = SPEED_W;
  localparam int CNT_W = $clog2(STEPS);

  localparam logic [SPEED_W-1:0] LED_THRESHOLD = 8'd10;
  localparam logic [DUR_W-1:0]   POWER_OFF_MS  = 16'd250;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_SMOOTH = 2'd2,
    CMD_OFF    = 2'd3
  } command_e_t;

  typedef enum logic {
    CFG_ENABLED     = 1'b0,
    CFG_LED_ENABLED = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/pdr_cmd_if.sv
`default_nettype none
interface pdr_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [pdr_pkg::SPEED_W-1:0] speed;
  logic [pdr_pkg::DUR_W-1:0]   duration_ms;

  modport source (output valid, command, speed, duration_ms, input ready);
  modport sink (input valid, command, speed, duration_ms, output ready);
endinterface
`default_nettype wire

FILE: rtl/pdr_res_if.sv
`default_nettype none
interface pdr_res_if;
  logic                        valid;
  logic                        ready;
  logic [pdr_pkg::SPEED_W-1:0] duty;
  logic                        status_led;
  logic                        ramping;

  modport source (output valid, duty, status_led, ramping, input ready);
  modport sink (input valid, duty, status_led, ramping, output ready);
endinterface
`default_nettype wire

FILE: rtl/pdr_cfg_if.sv
`default_nettype none
interface pdr_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pdr_mul.sv
`default_nettype none
module pdr_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pdr_pkg::SPEED_W-1:0] base,
  input  wire logic [pdr_pkg::SPEED_W-1:0] target,
  input  wire logic [pdr_pkg::DUR_W-1:0]   len,
  input  wire logic [pdr_pkg::DUR_W-1:0]   elapsed,
  output logic                             done,
  output logic [pdr_pkg::NUM_W-1:0]        product
);
  import pdr_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [SPEED_W-1:0] base_sh;
  logic [SPEED_W-1:0] target_sh;
  logic [DUR_W-1:0]   remain;
  logic [DUR_W-1:0]   passed;
  logic [NUM_W-1:0]   acc;
  logic [NUM_W-1:0]   acc_next;

  // One bit of both speed operands per cycle, most significant first.
  always_comb begin
    acc_next = {acc[NUM_W-2:0], 1'b0};
    if (base_sh[SPEED_W-1]) acc_next = acc_next + NUM_W'(remain);
    if (target_sh[SPEED_W-1]) acc_next = acc_next + NUM_W'(passed);
  end

  // Control: a fixed count of steps after each start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand shift registers and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      base_sh   <= base;
      target_sh <= target;
      remain    <= len - elapsed;
      passed    <= elapsed;
      acc       <= '0;
    end else if (busy) begin
      base_sh   <= {base_sh[SPEED_W-2:0], 1'b0};
      target_sh <= {target_sh[SPEED_W-2:0], 1'b0};
      acc       <= acc_next;
    end
  end

  assign product = acc;
endmodule
`default_nettype wire

FILE: rtl/pdr_div.sv
`default_nettype none
module pdr_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pdr_pkg::NUM_W-1:0]   num,
  input  wire logic [pdr_pkg::DUR_W-1:0]   den,
  output logic                             done,
  output logic [pdr_pkg::SPEED_W-1:0]      quot
);
  import pdr_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DUR_W-1:0]   rem;
  logic [SPEED_W-1:0] num_sh;
  logic [DUR_W:0]     trial;
  logic [DUR_W:0]     diff;
  logic               fits;

  // Restoring step: bring down one numerator bit, subtract when it fits.
  // The quotient is below 256, so the upper numerator bits start below den.
  always_comb begin
    trial = {rem, num_sh[SPEED_W-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num[NUM_W-1:SPEED_W];
      num_sh <= num[SPEED_W-1:0];
      quot   <= '0;
    end else if (busy) begin
      rem    <= fits ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
      num_sh <= {num_sh[SPEED_W-2:0], 1'b0};
      quot   <= {quot[SPEED_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pwm_duty_linear_ramp.sv
`default_nettype none
// Channel  Role    Payload
// cmd      sink    command, speed, duration_ms
// res      source  duty, status_led, ramping
// cfg      sink    index (0 enabled, 1 status_led_enabled), data
//
// One item at a time. A tick inside a ramp, short of its end, passes from accept
// through the load state, the bit-serial multiply, the restoring divider (each of
// 8 one-bit steps and a done strobe), the done state and the output register.
// Any other item goes from accept to the done state and the output register.
// The next item is taken while a result waits; its own result then stalls until
// the held one is taken. rst is synchronous and clears control, config and ramp
// state and res.valid, not result data. Configuration writes are always taken.
module pwm_duty_linear_ramp (
  input  wire logic clk,
  input  wire logic rst,
  pdr_cmd_if.sink   cmd,
  pdr_res_if.source res,
  pdr_cfg_if.sink   cfg
);
  import pdr_pkg::*;

  state_t state;
  state_t state_next;

  logic               enabled;
  logic               status_led_enabled;
  logic [SPEED_W-1:0] committed_speed;
  logic [SPEED_W-1:0] target_level;
  logic [DUR_W-1:0]   ramp_length;
  logic [DUR_W-1:0]   elapsed_ticks;
  logic [DUR_W-1:0]   elapsed_inc;
  logic [SPEED_W-1:0] duty_out;

  logic               cmd_acc;
  logic               tick_mid;
  logic               mul_start;
  logic               mul_done;
  logic [NUM_W-1:0]   mul_product;
  logic               div_done;
  logic [SPEED_W-1:0] div_quot;
  logic               res_load;

  assign cmd_acc     = cmd.valid && cmd.ready;
  assign elapsed_inc = elapsed_ticks + DUR_W'(1);
  // A tick that lands strictly inside a running ramp needs interpolation.
  assign tick_mid    = enabled && (command_e_t'(cmd.command) == CMD_TICK)
                       && (ramp_length != '0) && (elapsed_inc != ramp_length);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_acc) state_next = tick_mid ? ST_LOAD : ST_DONE;
      ST_LOAD: state_next = ST_MUL;
      ST_MUL:  if (mul_done) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_DONE;
      ST_DONE: if (!res.valid || res.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    cmd.ready = 1'b0;
    mul_start = 1'b0;
    res_load  = 1'b0;
    unique case (state)
      ST_IDLE: cmd.ready = 1'b1;
      ST_LOAD: mul_start = 1'b1;
      ST_DONE: res_load = !res.valid || res.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled            <= 1'b0;
      status_led_enabled <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_ENABLED:     enabled <= cfg.data;
        CFG_LED_ENABLED: status_led_enabled <= cfg.data;
        default: ;
      endcase
    end
  end

  // Command decode and ramp state.
  always_ff @(posedge clk) begin
    if (rst) begin
      committed_speed <= '0;
      target_level    <= '0;
      ramp_length     <= '0;
      elapsed_ticks   <= '0;
      duty_out        <= '0;
    end else if (cmd_acc && enabled) begin
      unique case (command_e_t'(cmd.command))
        CMD_TICK: begin
          if (ramp_length != '0) begin
            if (elapsed_inc == ramp_length) begin
              committed_speed <= target_level;
              duty_out        <= target_level;
              ramp_length     <= '0;
            end
            elapsed_ticks <= elapsed_inc;
          end
        end
        CMD_SET: begin
          target_level    <= cmd.speed;
          ramp_length     <= '0;
          committed_speed <= cmd.speed;
          duty_out        <= cmd.speed;
        end
        CMD_SMOOTH: begin
          target_level  <= cmd.speed;
          ramp_length   <= cmd.duration_ms;
          elapsed_ticks <= '0;
        end
        CMD_OFF: begin
          target_level  <= '0;
          ramp_length   <= POWER_OFF_MS;
          elapsed_ticks <= '0;
        end
        default: ;
      endcase
    end else if (state == ST_DIV && div_done) begin
      duty_out <= div_quot;
    end
  end

  // Interpolation: committed*(L-e) + target*e, then divide by L.
  pdr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .base    (committed_speed),
    .target  (target_level),
    .len     (ramp_length),
    .elapsed (elapsed_ticks),
    .done    (mul_done),
    .product (mul_product)
  );

  pdr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (mul_done),
    .num   (mul_product),
    .den   (ramp_length),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.duty       <= duty_out;
      res.status_led <= status_led_enabled && (committed_speed > LED_THRESHOLD);
      res.ramping    <= ramp_length != '0;
    end
  end

  // An accepted item always takes the block out of its idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> !cmd.ready)
    else $error("command accepted back to back");

  // Elapsed ticks stay below the ramp length while a ramp runs.
  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    (ramp_length != '0) |-> (elapsed_ticks < ramp_length))
    else $error("elapsed ticks reached ramp length");

  // The arithmetic units only run for a tick inside a ramp.
  a_mul_in_ramp: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> (ramp_length != '0))
    else $error("interpolation started without a ramp");

  // A loaded result reports the ramp flag of the state it was taken from.
  a_ramping_flag: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (res.ramping == (ramp_length != '0)))
    else $error("ramping flag mismatch");

endmodule
`default_nettype wire

FILE: sim/duty_ramp_checker.sv
`timescale 1ns / 1ps
module duty_ramp_checker
  import pdr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pdr_cmd_if   cmd,
  pdr_res_if   res,
  pdr_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding,
  output int   checked,
  output int   ramps_done
);

  typedef struct packed {
    logic [SPEED_W-1:0] duty;
    logic               status_led;
    logic               ramping;
  } fan_result_t;

  // Results owed by the block, oldest first.
  fan_result_t expected_q[$];

  // Shadow of the controller state and its two registers.
  logic               enabled_r;
  logic               led_enabled_r;
  logic [SPEED_W-1:0] committed;
  logic [SPEED_W-1:0] target;
  logic [SPEED_W-1:0] duty_now;
  logic [DUR_W-1:0]   ramp_len;
  logic [DUR_W-1:0]   elapsed;

  int n_fail;
  int n_checked;
  int n_ramps;

  // Applies one command item to the shadow state and queues the result it owes.
  task automatic predict_duty(input command_e_t op, input logic [SPEED_W-1:0] spd,
                              input logic [DUR_W-1:0] dur);
    logic [31:0] weighted;
    fan_result_t r;
    if (enabled_r) begin
      case (op)
        CMD_TICK: begin
          // Ticks only matter while a ramp runs.
          if (ramp_len != '0) begin
            elapsed = elapsed + 1'b1;
            if (elapsed >= ramp_len) begin
              committed = target;
              duty_now  = target;
              ramp_len  = '0;
              n_ramps++;
            end else begin
              // Exact interpolation between the committed speed and the target.
              weighted = 32'(committed) * 32'(ramp_len - elapsed)
                       + 32'(target) * 32'(elapsed);
              duty_now = SPEED_W'(weighted / 32'(ramp_len));
            end
          end
        end
        CMD_SET: begin
          target    = spd;
          ramp_len  = '0;
          committed = spd;
          duty_now  = spd;
        end
        CMD_SMOOTH: begin
          target   = spd;
          ramp_len = dur;
          elapsed  = '0;
        end
        default: begin
          target   = '0;
          ramp_len = POWER_OFF_MS;
          elapsed  = '0;
        end
      endcase
    end
    r.duty       = duty_now;
    r.status_led = led_enabled_r && (committed > LED_THRESHOLD);
    r.ramping    = (ramp_len != '0);
    expected_q.push_back(r);
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    fan_result_t want;
    fan_result_t got;
    if (rst) begin
      expected_q.delete();
      enabled_r     = 1'b0;
      led_enabled_r = 1'b0;
      committed     = '0;
      target        = '0;
      duty_now      = '0;
      ramp_len      = '0;
      elapsed       = '0;
      n_fail        = 0;
      n_checked     = 0;
      n_ramps       = 0;
    end else begin
      // Register writes.
      if (cfg.valid && cfg.ready) begin
        case (cfg_index_t'(cfg.index))
          CFG_ENABLED:     enabled_r = cfg.data;
          CFG_LED_ENABLED: led_enabled_r = cfg.data;
          default: ;
        endcase
      end

      // Accepted command items.
      if (cmd.valid && cmd.ready)
        predict_duty(command_e_t'(cmd.command), cmd.speed, cmd.duration_ms);

      // Accepted result items, compared with the oldest expectation.
      if (res.valid && res.ready) begin
        got.duty       = res.duty;
        got.status_led = res.status_led;
        got.ramping    = res.ramping;
        n_checked++;
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] unexpected result: duty=%0d led=%0b ramping=%0b",
                     $realtime, got.duty, got.status_led, got.ramping);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("[%0t] result %0d: expected duty=%0d led=%0b ramping=%0b, got duty=%0d led=%0b ramping=%0b",
                       $realtime, n_checked, want.duty, want.status_led, want.ramping,
                       got.duty, got.status_led, got.ramping);
          end
        end
      end
    end
    fail_count  <= n_fail;
    outstanding <= expected_q.size();
    checked     <= n_checked;
    ramps_done  <= n_ramps;
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pdr_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 950;

  // Register settings per phase: {enabled, status_led_enabled}.
  localparam logic [1:0] PHASE_CFG [6] = '{2'b11, 2'b10, 2'b01, 2'b11, 2'b00, 2'b11};

  logic clk;
  logic rst;
  logic quiet;
  int   cycles = 0;
  int   items_sent = 0;
  int   settings_used = 0;
  int   fail_count;
  int   outstanding;
  int   checked;
  int   ramps_done;

  pdr_cmd_if cmd_ch ();
  pdr_res_if res_ch ();
  pdr_cfg_if cfg_ch ();

  pwm_duty_linear_ramp u_dut (
    .clk,
    .rst,
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  duty_ramp_checker u_checker (
    .clk,
    .rst,
    .cmd         (cmd_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .ramps_done  (ramps_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, outstanding);
      $display("** pwm_duty_linear_ramp: FAILED **");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 96)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random fill for fields that a command may ignore.
  function automatic logic [SPEED_W-1:0] rand_speed();
    return SPEED_W'($urandom);
  endfunction

  function automatic logic [DUR_W-1:0] rand_dur();
    return DUR_W'($urandom);
  endfunction

  // Result side: random stalls between runs of ready.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Offers one command item and waits for it to be taken. Valid stays high
  // when no gap follows, so back-to-back items need no extra edge.
  task automatic send_item(input command_e_t op, input logic [SPEED_W-1:0] spd,
                           input logic [DUR_W-1:0] dur);
    int gap;
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= op;
    cmd_ch.speed       <= spd;
    cmd_ch.duration_ms <= dur;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off commands until every owed result has come back.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes both registers while the block is idle.
  task automatic write_settings(input logic en, input logic led);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_ENABLED;
    cfg_ch.data  <= en;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_LED_ENABLED;
    cfg_ch.data  <= led;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // One random burst: often a ramp followed by enough ticks to finish it, else
  // interrupted or long ramps, sets, power-offs, zero-length ramps and plain noise.
  task automatic run_random_sequence();
    int pick;
    int n;
    logic [DUR_W-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      len = DUR_W'($urandom_range(1, 12));
      n = int'(len) + int'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0)
        n = int'($urandom_range(0, n - 1));
      send_item(CMD_SMOOTH, rand_speed(), len);
      repeat (n) send_item(CMD_TICK, rand_speed(), rand_dur());
    end else if (pick < 55) begin
      // Long ramps exercise the divider with wide lengths.
      len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : DUR_W'($urandom_range(13, 65535));
      send_item(CMD_SMOOTH, rand_speed(), len);
      repeat ($urandom_range(1, 6)) send_item(CMD_TICK, rand_speed(), rand_dur());
    end else if (pick < 65) begin
      send_item(CMD_SET, rand_speed(), rand_dur());
      repeat ($urandom_range(0, 2)) send_item(CMD_TICK, rand_speed(), rand_dur());
    end else if (pick < 72) begin
      send_item(CMD_OFF, rand_speed(), rand_dur());
      repeat ($urandom_range(1, 10)) send_item(CMD_TICK, rand_speed(), rand_dur());
    end else if (pick < 80) begin
      send_item(CMD_SMOOTH, rand_speed(), '0);
      send_item(CMD_TICK, rand_speed(), rand_dur());
    end else begin
      repeat ($urandom_range(1, 4))
        send_item(command_e_t'(2'($urandom_range(0, 3))), rand_speed(), rand_dur());
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int phase;
    int phase_start;
    int budget;
    logic [1:0] setting;

    rst                <= 1'b1;
    quiet              <= 1'b0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.command     <= CMD_TICK;
    cmd_ch.speed       <= '0;
    cmd_ch.duration_ms <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_ENABLED;
    cfg_ch.data        <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // While disabled every command is ignored, a set speed included.
    write_settings(1'b0, 1'b1);
    send_item(CMD_SET, 8'd200, 16'hFFFF);
    send_item(CMD_SMOOTH, 8'd90, 16'd3);
    send_item(CMD_TICK, 8'd0, 16'd0);

    // Enabling alone changes nothing; a tick with no ramp is a no-op.
    write_settings(1'b1, 1'b1);
    send_item(CMD_TICK, 8'hFF, 16'hFFFF);
    send_item(CMD_SET, 8'd255, 16'd0);
    send_item(CMD_SET, 8'd10, 16'd7);
    send_item(CMD_SET, 8'd11, 16'd0);

    // A zero-length ramp stores the target but applies nothing.
    send_item(CMD_SMOOTH, 8'd255, 16'd0);
    send_item(CMD_TICK, 8'd0, 16'd0);

    // A short ramp run to completion.
    send_item(CMD_SMOOTH, 8'd200, 16'd3);
    repeat (3) send_item(CMD_TICK, rand_speed(), rand_dur());

    // Longest ramp, then replaced by a set speed.
    send_item(CMD_SMOOTH, 8'd0, 16'hFFFF);
    repeat (2) send_item(CMD_TICK, rand_speed(), rand_dur());
    send_item(CMD_SET, 8'd50, 16'd0);

    // One-tick ramp, and a ramp replaced after its first tick by another.
    send_item(CMD_SMOOTH, 8'd255, 16'd1);
    send_item(CMD_TICK, 8'd0, 16'd0);
    send_item(CMD_SMOOTH, 8'd0, 16'd4);
    send_item(CMD_TICK, 8'd0, 16'd0);
    send_item(CMD_SMOOTH, 8'd100, 16'd2);
    repeat (2) send_item(CMD_TICK, rand_speed(), rand_dur());

    // Power off ignores its speed and duration fields.
    send_item(CMD_OFF, 8'hA5, 16'h5A5A);
    repeat (2) send_item(CMD_TICK, rand_speed(), rand_dur());

    // Random phases, each with its own register setting.
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      setting = PHASE_CFG[phase % 6];
      write_settings(setting[1], setting[0]);
      quiet <= (phase % 6 == 3);
      phase_start = items_sent;
      if (phase == 0) begin
        // A full power-off ramp from a high speed down to zero.
        send_item(CMD_SET, SPEED_W'($urandom_range(180, 255)), rand_dur());
        send_item(CMD_OFF, rand_speed(), rand_dur());
        repeat (int'(POWER_OFF_MS)) send_item(CMD_TICK, rand_speed(), rand_dur());
      end
      budget = setting[1] ? 180 : 30;
      while (items_sent - phase_start < budget && items_sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 39) == 0)
          wait_drained();
        run_random_sequence();
      end
      phase++;
    end
    quiet <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run covered %0d command items under %0d register settings.",
             items_sent, settings_used);
    $display("%0d results checked, %0d ramps ran through to their target.",
             checked, ramps_done);
    if (fail_count == 0 && outstanding == 0)
      $display("** pwm_duty_linear_ramp: PASSED **");
    else
      $display("** pwm_duty_linear_ramp: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
rtl/pdr_pkg.sv
rtl/pdr_cmd_if.sv
rtl/pdr_res_if.sv
rtl/pdr_cfg_if.sv
rtl/pdr_mul.sv
rtl/pdr_div.sv
rtl/pwm_duty_linear_ramp.sv
sim/duty_ramp_checker.sv
sim/tb_top.sv
